>>> rtl/gtsc_pkg.sv
// shared widths, limits and register codes for the glass-tile address generator
`timescale 1ns / 1ps
`default_nettype none
package gtsc_pkg;

    localparam int MAX_WIDTH  = 4096;
    localparam int MAX_HEIGHT = 4096;

    localparam int COORD_W  = 12;   // coordinate fields
    localparam int EXTENT_W = 13;   // region width and bottom, up to the maximum itself
    localparam int TILE_W   = 6;    // tile size registers
    localparam int OFFS_W   = 6;    // signed offset inside a tile
    localparam int CENTRE_W = 13;   // saturating tile centre
    localparam int SUM_W    = 15;   // signed centre plus twice the offset

    localparam int ADDR_W = 5;
    localparam int DATA_W = 32;

    localparam logic [2:0] REG_TILE_WIDTH    = 3'd0;
    localparam logic [2:0] REG_TILE_HEIGHT   = 3'd1;
    localparam logic [2:0] REG_REGION_WIDTH  = 3'd2;
    localparam logic [2:0] REG_REGION_TOP    = 3'd3;
    localparam logic [2:0] REG_REGION_BOTTOM = 3'd4;

    localparam logic [TILE_W-1:0]   TILE_RESET   = TILE_W'(20);
    localparam logic [EXTENT_W-1:0] WIDTH_LIMIT  = EXTENT_W'(MAX_WIDTH);
    localparam logic [EXTENT_W-1:0] HEIGHT_LIMIT = EXTENT_W'(MAX_HEIGHT);

    // tile centre plus a step, held at the top of the range once it runs over
    function automatic logic [CENTRE_W-1:0] centre_add(input logic [CENTRE_W-1:0] centre,
                                                       input logic [TILE_W-1:0]   step);
        logic [CENTRE_W:0] sum;
        sum = {1'b0, centre} + {{(CENTRE_W - TILE_W + 1){1'b0}}, step};
        return sum[CENTRE_W] ? {CENTRE_W{1'b1}} : sum[CENTRE_W-1:0];
    endfunction

    // centre plus twice a signed offset, as a signed sum
    function automatic logic signed [SUM_W-1:0] centre_sum(input logic [CENTRE_W-1:0] centre,
                                                          input logic signed [OFFS_W-1:0] offs);
        logic signed [SUM_W-1:0] c;
        logic signed [SUM_W-1:0] o;
        c = $signed({{(SUM_W - CENTRE_W){1'b0}}, centre});
        o = SUM_W'(offs);
        return c + (o <<< 1);
    endfunction

endpackage
`default_nettype wire

>>> rtl/glass_tile_source_coordinates.sv
// top level: glass-tile source address generator with its register file
// ---------------------------------------------------------------------------
// usage
//   input channel s_*: one transfer per destination pixel. s_restart = 1 starts
//   a new pass at row region_top, column 0; s_restart = 0 moves on one pixel
//   in scan order. after the last pixel of the region the next transfer
//   starts a new pass by itself.
//   result channel m_*: one transfer per input transfer, carrying the
//   destination pixel, the source pixel to copy from, and row/frame end flags.
//   the user writes registers over apb only while the block is idle, which the
//   block does not enforce; pready is always high, reads return stored values.
// timing
//   the result is in the output register the cycle after the input transfer.
//   throughput is one pixel per cycle while the receiver does not stall; all
//   address work is a single combinational pass between the scan counters
//   and the output register.
// stall and reset
//   s_ready is high while the output register is empty or being drained, so a
//   stalled receiver stops the input after one held result. aresetn
//   (synchronous, active low) empties the output register, zeroes the scan
//   counters and loads the register reset values.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module glass_tile_source_coordinates (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    // apb register port
    input  wire logic                            psel,
    input  wire logic                            penable,
    input  wire logic                            pwrite,
    input  wire logic [gtsc_pkg::ADDR_W-1:0]     paddr,
    input  wire logic [gtsc_pkg::DATA_W-1:0]     pwdata,
    output logic      [gtsc_pkg::DATA_W-1:0]     prdata,
    output logic                                 pready,
    // input channel
    input  wire logic                            s_valid,
    output logic                                 s_ready,
    input  wire logic                            s_restart,
    // result channel
    output logic                                 m_valid,
    input  wire logic                            m_ready,
    output logic      [gtsc_pkg::COORD_W-1:0]    m_dest_column,
    output logic      [gtsc_pkg::COORD_W-1:0]    m_dest_row,
    output logic      [gtsc_pkg::COORD_W-1:0]    m_source_column,
    output logic      [gtsc_pkg::COORD_W-1:0]    m_source_row,
    output logic                                 m_row_end,
    output logic                                 m_frame_end
);
    import gtsc_pkg::*;

    // ---------------- register file ----------------
    logic [TILE_W-1:0]   tile_width_reg;
    logic [TILE_W-1:0]   tile_height_reg;
    logic [EXTENT_W-1:0] region_width_reg;
    logic [COORD_W-1:0]  region_top_reg;
    logic [EXTENT_W-1:0] region_bottom_reg;

    logic       cfg_write;
    logic [2:0] cfg_index;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;
    assign cfg_index = paddr[4:2];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tile_width_reg    <= TILE_RESET;
            tile_height_reg   <= TILE_RESET;
            region_width_reg  <= WIDTH_LIMIT;
            region_top_reg    <= '0;
            region_bottom_reg <= HEIGHT_LIMIT;
        end else if (cfg_write) begin
            unique case (cfg_index)
                REG_TILE_WIDTH:    tile_width_reg    <= pwdata[TILE_W-1:0];
                REG_TILE_HEIGHT:   tile_height_reg   <= pwdata[TILE_W-1:0];
                REG_REGION_WIDTH:  region_width_reg  <= pwdata[EXTENT_W-1:0];
                REG_REGION_TOP:    region_top_reg    <= pwdata[COORD_W-1:0];
                REG_REGION_BOTTOM: region_bottom_reg <= pwdata[EXTENT_W-1:0];
                default: ;  // unmapped addresses are ignored
            endcase
        end
    end

    always_comb begin
        prdata = '0;
        unique case (cfg_index)
            REG_TILE_WIDTH:    prdata = DATA_W'(tile_width_reg);
            REG_TILE_HEIGHT:   prdata = DATA_W'(tile_height_reg);
            REG_REGION_WIDTH:  prdata = DATA_W'(region_width_reg);
            REG_REGION_TOP:    prdata = DATA_W'(region_top_reg);
            REG_REGION_BOTTOM: prdata = DATA_W'(region_bottom_reg);
            default:           prdata = '0;
        endcase
    end

    // ---------------- effective settings ----------------
    // tiles below two pixels act as two; width and bottom are held to 1..limit
    logic [TILE_W-1:0]   tw, th;
    logic [TILE_W-2:0]   hw, hh;
    logic [TILE_W-1:0]   tw_rest, th_rest;
    logic [EXTENT_W-1:0] ew, eb, eb_last;

    always_comb begin
        tw = (tile_width_reg  < TILE_W'(2)) ? TILE_W'(2) : tile_width_reg;
        th = (tile_height_reg < TILE_W'(2)) ? TILE_W'(2) : tile_height_reg;
        hw = tw[TILE_W-1:1];
        hh = th[TILE_W-1:1];
        tw_rest = tw - {1'b0, hw};
        th_rest = th - {1'b0, hh};

        if (region_width_reg == '0)            ew = EXTENT_W'(1);
        else if (region_width_reg > WIDTH_LIMIT) ew = WIDTH_LIMIT;
        else                                    ew = region_width_reg;

        if (region_bottom_reg == '0)             eb = EXTENT_W'(1);
        else if (region_bottom_reg > HEIGHT_LIMIT) eb = HEIGHT_LIMIT;
        else                                      eb = region_bottom_reg;
        eb_last = eb - EXTENT_W'(1);
    end

    // ---------------- scan state ----------------
    logic [COORD_W-1:0]         column_count_reg, column_count_next;
    logic [COORD_W-1:0]         row_count_reg,    row_count_next;
    logic [CENTRE_W-1:0]        column_centre_reg, column_centre_next;
    logic signed [OFFS_W-1:0]   column_offset_reg, column_offset_next;
    logic [CENTRE_W-1:0]        row_centre_reg,   row_centre_next;
    logic signed [OFFS_W-1:0]   row_offset_reg,   row_offset_next;
    logic [COORD_W-1:0]         row_source_reg,   row_source_next;

    // output register
    logic                       m_valid_reg;
    logic [COORD_W-1:0]         dest_column_reg, dest_column_next;
    logic [COORD_W-1:0]         dest_row_reg,    dest_row_next;
    logic [COORD_W-1:0]         source_column_reg, source_column_next;
    logic [COORD_W-1:0]         source_row_reg;
    logic                       row_end_reg,   row_end_next;
    logic                       frame_end_reg, frame_end_next;

    logic s_take;
    assign s_ready = !m_valid_reg || m_ready;
    assign s_take  = s_valid && s_ready;

    // working copies after a possible restart
    logic [COORD_W-1:0]       cc, rc;
    logic [CENTRE_W-1:0]      ccen, rcen;
    logic signed [OFFS_W-1:0] coff, roff;
    logic signed [SUM_W-1:0]  row_sum, col_sum;
    logic signed [OFFS_W:0]   roff_inc, coff_inc;

    always_comb begin
        // restart reloads the pass start
        if (s_restart) begin
            cc   = '0;
            rc   = region_top_reg;
            rcen = {1'b0, region_top_reg};
            roff = '0;
            ccen = '0;
            coff = '0;
        end else begin
            cc   = column_count_reg;
            rc   = row_count_reg;
            rcen = row_centre_reg;
            roff = row_offset_reg;
            ccen = column_centre_reg;
            coff = column_offset_reg;
        end

        // first column of a row: latch the source row, step the vertical counters
        row_sum         = centre_sum(rcen, roff);
        roff_inc        = (OFFS_W + 1)'(roff) + (OFFS_W + 1)'(1);
        row_source_next = row_source_reg;
        row_centre_next = rcen;
        row_offset_next = roff;
        if (cc == '0) begin
            if (row_sum < 0)
                row_source_next = '0;
            else if (row_sum >= $signed({{(SUM_W - EXTENT_W){1'b0}}, eb}))
                row_source_next = eb_last[COORD_W-1:0];
            else
                row_source_next = row_sum[COORD_W-1:0];

            if (roff_inc >= $signed({2'b00, hh})) begin
                row_centre_next = centre_add(rcen, th);
                row_offset_next = OFFS_W'(0) - $signed(th_rest);
            end else begin
                row_offset_next = roff_inc[OFFS_W-1:0];
            end
            ccen = '0;
            coff = '0;
        end

        // source column, 0 when negative, the own column past the right edge
        col_sum = centre_sum(ccen, coff);
        if (col_sum >= $signed({{(SUM_W - EXTENT_W){1'b0}}, ew}))
            source_column_next = cc;
        else if (col_sum < 0)
            source_column_next = '0;
        else
            source_column_next = col_sum[COORD_W-1:0];

        row_end_next     = ({1'b0, cc} + EXTENT_W'(1)) >= ew;
        frame_end_next   = row_end_next && (({1'b0, rc} + EXTENT_W'(1)) >= eb);
        dest_column_next = cc;
        dest_row_next    = rc;

        // horizontal tile counters
        coff_inc = (OFFS_W + 1)'(coff) + (OFFS_W + 1)'(1);
        if (coff_inc >= $signed({2'b00, hw})) begin
            column_centre_next = centre_add(ccen, tw);
            column_offset_next = OFFS_W'(0) - $signed(tw_rest);
        end else begin
            column_centre_next = ccen;
            column_offset_next = coff_inc[OFFS_W-1:0];
        end

        // scan position
        column_count_next = cc + COORD_W'(1);
        row_count_next    = rc;
        if (row_end_next) begin
            column_count_next = '0;
            if (frame_end_next) begin
                // wrap to a fresh pass
                row_count_next     = region_top_reg;
                row_centre_next    = {1'b0, region_top_reg};
                row_offset_next    = '0;
                column_centre_next = '0;
                column_offset_next = '0;
            end else begin
                row_count_next = rc + COORD_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            column_count_reg  <= '0;
            row_count_reg     <= '0;
            column_centre_reg <= '0;
            column_offset_reg <= '0;
            row_centre_reg    <= '0;
            row_offset_reg    <= '0;
            row_source_reg    <= '0;
            m_valid_reg       <= 1'b0;
        end else begin
            if (s_take) begin
                column_count_reg  <= column_count_next;
                row_count_reg     <= row_count_next;
                column_centre_reg <= column_centre_next;
                column_offset_reg <= column_offset_next;
                row_centre_reg    <= row_centre_next;
                row_offset_reg    <= row_offset_next;
                row_source_reg    <= row_source_next;
                m_valid_reg       <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // result payload, loaded on each input transfer
    always_ff @(posedge aclk) begin
        if (s_take) begin
            dest_column_reg   <= dest_column_next;
            dest_row_reg      <= dest_row_next;
            source_column_reg <= source_column_next;
            source_row_reg    <= row_source_next;
            row_end_reg       <= row_end_next;
            frame_end_reg     <= frame_end_next;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_dest_column   = dest_column_reg;
    assign m_dest_row      = dest_row_reg;
    assign m_source_column = source_column_reg;
    assign m_source_row    = source_row_reg;
    assign m_row_end       = row_end_reg;
    assign m_frame_end     = frame_end_reg;

endmodule
`default_nettype wire

>>> rtl/gtsc_checker.sv
// port-level checks for the glass-tile address generator, bound to the top level
`timescale 1ns / 1ps
`default_nettype none
module gtsc_checker (
    input wire logic                         aclk,
    input wire logic                         aresetn,
    input wire logic                         s_valid,
    input wire logic                         s_ready,
    input wire logic                         m_valid,
    input wire logic                         m_ready,
    input wire logic [gtsc_pkg::COORD_W-1:0] m_dest_column,
    input wire logic [gtsc_pkg::COORD_W-1:0] m_source_row,
    input wire logic                         m_row_end,
    input wire logic                         m_frame_end
);

    // a stalled result keeps its valid, destination column and source row
    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_dest_column)
                                   && $stable(m_source_row)))
        else $error("result changed while stalled");

    // every input transfer shows up as a result in the next cycle
    a_in_to_out: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> m_valid)
        else $error("input transfer without a result");

    // an empty output register never blocks the input
    a_ready_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid |-> s_ready)
        else $error("input blocked with an empty output register");

    // the last pixel of the region is also the last of its row
    a_frame_row: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_frame_end) |-> m_row_end)
        else $error("frame end without row end");

endmodule

bind glass_tile_source_coordinates gtsc_checker u_gtsc_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .s_valid       (s_valid),
    .s_ready       (s_ready),
    .m_valid       (m_valid),
    .m_ready       (m_ready),
    .m_dest_column (m_dest_column),
    .m_source_row  (m_source_row),
    .m_row_end     (m_row_end),
    .m_frame_end   (m_frame_end)
);
`default_nettype wire

>>> tb/glass_scan_checker.sv
// checker for the glass-tile address generator: tracks the scan, predicts each result and compares
`timescale 1ns / 1ps
module glass_scan_checker (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic                            pready,
    input  logic [gtsc_pkg::ADDR_W-1:0]     paddr,
    input  logic [gtsc_pkg::DATA_W-1:0]     pwdata,
    input  logic                            s_valid,
    input  logic                            s_ready,
    input  logic                            s_restart,
    input  logic                            m_valid,
    input  logic                            m_ready,
    input  logic [gtsc_pkg::COORD_W-1:0]    m_dest_column,
    input  logic [gtsc_pkg::COORD_W-1:0]    m_dest_row,
    input  logic [gtsc_pkg::COORD_W-1:0]    m_source_column,
    input  logic [gtsc_pkg::COORD_W-1:0]    m_source_row,
    input  logic                            m_row_end,
    input  logic                            m_frame_end,
    output int                              fail_count,
    output int                              open_count,
    output int                              result_count,
    output int                              frame_count
);
    import gtsc_pkg::*;

    typedef struct packed {
        logic [COORD_W-1:0] dest_column;
        logic [COORD_W-1:0] dest_row;
        logic [COORD_W-1:0] source_column;
        logic [COORD_W-1:0] source_row;
        logic               row_end;
        logic               frame_end;
    } scan_pixel_t;

    // register copies
    logic [TILE_W-1:0]   cfg_tile_w;
    logic [TILE_W-1:0]   cfg_tile_h;
    logic [EXTENT_W-1:0] cfg_width;
    logic [COORD_W-1:0]  cfg_top;
    logic [EXTENT_W-1:0] cfg_bottom;

    // scan position and tile counters
    int scan_col;
    int scan_row;
    int col_centre;
    int col_offs;
    int row_centre;
    int row_offs;
    int row_src;

    scan_pixel_t expected_pixels[$];
    scan_pixel_t want;
    int          errors = 0;
    int          seen = 0;
    int          frames = 0;

    function automatic void begin_pass();
        scan_col   = 0;
        scan_row   = int'(cfg_top);
        row_centre = int'(cfg_top);
        row_offs   = 0;
        col_centre = 0;
        col_offs   = 0;
    endfunction

    function automatic scan_pixel_t next_pixel(input logic restart);
        int          tw;
        int          th;
        int          ew;
        int          eb;
        int          src;
        scan_pixel_t px;
        tw = (cfg_tile_w < 2) ? 2 : int'(cfg_tile_w);
        th = (cfg_tile_h < 2) ? 2 : int'(cfg_tile_h);
        ew = (cfg_width == 0) ? 1 : ((cfg_width > MAX_WIDTH) ? MAX_WIDTH : int'(cfg_width));
        eb = (cfg_bottom == 0) ? 1 : ((cfg_bottom > MAX_HEIGHT) ? MAX_HEIGHT : int'(cfg_bottom));
        if (restart)
            begin_pass();
        // source row latched once per row, then the vertical counters step
        if (scan_col == 0) begin
            src = row_centre + 2 * row_offs;
            if (src < 0)
                src = 0;
            if (src > eb - 1)
                src = eb - 1;
            row_src = src;
            row_offs++;
            if (row_offs >= th / 2) begin
                row_centre += th;
                row_offs = -(th - th / 2);
            end
            col_centre = 0;
            col_offs   = 0;
        end
        src = col_centre + 2 * col_offs;
        if (src >= ew)
            px.source_column = COORD_W'(scan_col);
        else if (src < 0)
            px.source_column = '0;
        else
            px.source_column = COORD_W'(src);
        px.dest_column = COORD_W'(scan_col);
        px.dest_row    = COORD_W'(scan_row);
        px.source_row  = COORD_W'(row_src);
        px.row_end     = (scan_col + 1 >= ew);
        px.frame_end   = px.row_end && (scan_row + 1 >= eb);
        col_offs++;
        if (col_offs >= tw / 2) begin
            col_centre += tw;
            col_offs = -(tw - tw / 2);
        end
        if (px.row_end) begin
            scan_col = 0;
            if (px.frame_end)
                begin_pass();
            else
                scan_row++;
        end else begin
            scan_col++;
        end
        return px;
    endfunction

    task automatic check_field(input string field, input logic [COORD_W-1:0] exp_v,
                               input logic [COORD_W-1:0] got_v);
        if (got_v !== exp_v) begin
            errors++;
            $display("%0t mismatch on %s: expected %0d, actual %0d",
                     $time, field, exp_v, got_v);
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            cfg_tile_w = TILE_RESET;
            cfg_tile_h = TILE_RESET;
            cfg_width  = WIDTH_LIMIT;
            cfg_top    = '0;
            cfg_bottom = HEIGHT_LIMIT;
            scan_col   = 0;
            scan_row   = 0;
            col_centre = 0;
            col_offs   = 0;
            row_centre = 0;
            row_offs   = 0;
            row_src    = 0;
            expected_pixels.delete();
        end else begin
            if (psel && penable && pwrite && pready) begin
                case (paddr[ADDR_W-1:2])
                    REG_TILE_WIDTH:    cfg_tile_w = pwdata[TILE_W-1:0];
                    REG_TILE_HEIGHT:   cfg_tile_h = pwdata[TILE_W-1:0];
                    REG_REGION_WIDTH:  cfg_width  = pwdata[EXTENT_W-1:0];
                    REG_REGION_TOP:    cfg_top    = pwdata[COORD_W-1:0];
                    REG_REGION_BOTTOM: cfg_bottom = pwdata[EXTENT_W-1:0];
                    default: ;
                endcase
            end
            // output is registered, so a result never belongs to this edge's input
            if (m_valid && m_ready) begin
                seen++;
                if (expected_pixels.size() == 0) begin
                    errors++;
                    $display("%0t unexpected result: expected none, actual column %0d row %0d",
                             $time, m_dest_column, m_dest_row);
                end else begin
                    want = expected_pixels.pop_front();
                    if (want.frame_end)
                        frames++;
                    check_field("dest_column", want.dest_column, m_dest_column);
                    check_field("dest_row", want.dest_row, m_dest_row);
                    check_field("source_column", want.source_column, m_source_column);
                    check_field("source_row", want.source_row, m_source_row);
                    check_field("row_end", COORD_W'(want.row_end), COORD_W'(m_row_end));
                    check_field("frame_end", COORD_W'(want.frame_end), COORD_W'(m_frame_end));
                end
            end
            if (s_valid && s_ready)
                expected_pixels.push_back(next_pixel(s_restart));
        end
        fail_count   <= errors;
        open_count   <= expected_pixels.size();
        result_count <= seen;
        frame_count  <= frames;
    end

endmodule

>>> tb/tb.sv
// testbench top: drives pixel requests and register writes into the glass-tile address generator
`timescale 1ns / 1ps
module tb;

    // -----------------------------------------------------------------------
    // clock, reset and every block input, all known from time zero
    // -----------------------------------------------------------------------
    logic aclk = 1'b0;
    logic aresetn = 1'b0;

    logic                          psel = 1'b0;
    logic                          penable = 1'b0;
    logic                          pwrite = 1'b0;
    logic [gtsc_pkg::ADDR_W-1:0]   paddr = '0;
    logic [gtsc_pkg::DATA_W-1:0]   pwdata = '0;
    logic [gtsc_pkg::DATA_W-1:0]   prdata;
    logic                          pready;

    logic                          s_valid = 1'b0;
    logic                          s_ready;
    logic                          s_restart = 1'b0;

    logic                          m_valid;
    logic                          m_ready = 1'b0;
    logic [gtsc_pkg::COORD_W-1:0]  m_dest_column;
    logic [gtsc_pkg::COORD_W-1:0]  m_dest_row;
    logic [gtsc_pkg::COORD_W-1:0]  m_source_column;
    logic [gtsc_pkg::COORD_W-1:0]  m_source_row;
    logic                          m_row_end;
    logic                          m_frame_end;

    // verdict inputs from the checker
    int fail_count;
    int open_count;
    int result_count;
    int frame_count;

    // idling in percent: sender gap before each transfer, receiver stall per cycle
    int gap_pct = 0;
    int stall_pct = 0;
    int settings_made = 0;

    initial begin
        forever #5 aclk = ~aclk;
    end

    glass_tile_source_coordinates u_dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_restart       (s_restart),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_dest_column   (m_dest_column),
        .m_dest_row      (m_dest_row),
        .m_source_column (m_source_column),
        .m_source_row    (m_source_row),
        .m_row_end       (m_row_end),
        .m_frame_end     (m_frame_end)
    );

    glass_scan_checker u_checker (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .pready          (pready),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_restart       (s_restart),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_dest_column   (m_dest_column),
        .m_dest_row      (m_dest_row),
        .m_source_column (m_source_column),
        .m_source_row    (m_source_row),
        .m_row_end       (m_row_end),
        .m_frame_end     (m_frame_end),
        .fail_count      (fail_count),
        .open_count      (open_count),
        .result_count    (result_count),
        .frame_count     (frame_count)
    );

    // receiver back-pressure, redrawn every cycle
    always @(posedge aclk) begin
        m_ready <= ($urandom_range(99) >= stall_pct);
    end

    // -----------------------------------------------------------------------
    // register port: setup cycle then access cycle, psel left high so that
    // back-to-back writes never lower and raise it within one step
    // -----------------------------------------------------------------------
    task automatic write_reg(input logic [2:0] code, input int unsigned value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {code, 2'b00};
        pwdata  <= gtsc_pkg::DATA_W'(value);
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready)
            @(posedge aclk);
    endtask

    task automatic apb_release();
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // all five registers in one go
    task automatic program_region(input int unsigned tile_w, input int unsigned tile_h,
                                  input int unsigned width, input int unsigned top_row,
                                  input int unsigned bottom);
        write_reg(gtsc_pkg::REG_TILE_WIDTH, tile_w);
        write_reg(gtsc_pkg::REG_TILE_HEIGHT, tile_h);
        write_reg(gtsc_pkg::REG_REGION_WIDTH, width);
        write_reg(gtsc_pkg::REG_REGION_TOP, top_row);
        write_reg(gtsc_pkg::REG_REGION_BOTTOM, bottom);
        apb_release();
        settings_made++;
    endtask

    // one pixel request; valid stays up across back-to-back transfers and is
    // only dropped while the sender idles
    task automatic push_pixel(input logic restart_bit);
        while ($urandom_range(99) < gap_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid   <= 1'b1;
        s_restart <= restart_bit;
        @(posedge aclk);
        while (!s_ready)
            @(posedge aclk);
    endtask

    // drop valid and wait for every outstanding result; open_count is registered
    // in the checker, hence the first wait
    task automatic drain();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (open_count != 0)
            @(posedge aclk);
    endtask

    // tile sizes mostly in the useful range, now and then the corners
    function automatic int unsigned pick_tile();
        int unsigned pick;
        pick = $urandom_range(9);
        if (pick == 0) begin
            case ($urandom_range(4))
                0:       return 0;
                1:       return 1;
                2:       return 2;
                3:       return 3;
                default: return 63;
            endcase
        end
        return $urandom_range(10, 50);
    endfunction

    initial begin
        int unsigned tw;
        int unsigned th;
        int unsigned width;
        int unsigned top_row;
        int unsigned bottom;

        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        // -------------------------------------------------------------------
        // directed part
        // -------------------------------------------------------------------
        gap_pct   = 17;
        stall_pct = 82;

        // first pass after reset starts at row 0 even with a top row set
        write_reg(gtsc_pkg::REG_REGION_TOP, 7);
        apb_release();
        repeat (3) push_pixel(1'b0);

        // tile sizes below two, three-column region, bottom of zero so the
        // pass is one row long at the top row; frame end restarts by itself
        drain();
        program_region(0, 1, 3, 5, 0);
        push_pixel(1'b1);
        repeat (4) push_pixel(1'b0);

        // largest tiles, oversized width and bottom, last image row
        drain();
        program_region(63, 63, 8191, 4095, 8191);
        push_pixel(1'b1);
        repeat (2) push_pixel(1'b0);

        // odd tiles on a six-row region, so the source row runs past the bottom and clamps
        drain();
        program_region(11, 13, 2, 0, 6);
        push_pixel(1'b1);
        repeat (12) push_pixel(1'b0);
        push_pixel(1'b1);
        push_pixel(1'b0);

        // -------------------------------------------------------------------
        // random part: three idling modes, three settings each; state is
        // carried across settings so the new values also land mid-pass
        // -------------------------------------------------------------------
        for (int mode = 0; mode < 3; mode++) begin
            drain();
            case (mode)
                0: begin
                    gap_pct   = 17;
                    stall_pct = 82;
                end
                1: begin
                    gap_pct   = 82;
                    stall_pct = 17;
                end
                default: begin
                    gap_pct   = 0;
                    stall_pct = 0;
                end
            endcase
            repeat (3) begin
                drain();
                tw = pick_tile();
                th = pick_tile();
                case ($urandom_range(19))
                    0:       width = 0;
                    1:       width = 8191;
                    2:       width = 4096;
                    3:       width = $urandom_range(41, 8191);
                    default: width = $urandom_range(1, 24);
                endcase
                case ($urandom_range(9))
                    0:       top_row = 0;
                    1:       top_row = 4095;
                    default: top_row = $urandom_range(0, 4095);
                endcase
                // mostly a handful of rows, sometimes a degenerate bottom
                case ($urandom_range(9))
                    0:       bottom = 0;
                    1:       bottom = top_row;
                    2:       bottom = $urandom_range(0, top_row);
                    3:       bottom = 8191;
                    default: bottom = top_row + $urandom_range(1, 8);
                endcase
                program_region(tw, th, width, top_row, bottom);
                push_pixel(1'($urandom_range(1)));
                repeat (74) push_pixel($urandom_range(39) == 0);
            end
        end

        // start of a full-width row at the foot of the image
        drain();
        program_region(50, 49, 4096, 4094, 4096);
        push_pixel(1'b1);
        repeat (299) push_pixel(1'b0);

        drain();
        repeat (4) @(posedge aclk);

        $display("covered %0d pixel transfers over %0d register settings, %0d frame ends",
                 result_count, settings_made, frame_count);
        $display("idling mixes: sender-heavy, receiver-heavy and none; mismatches %0d",
                 fail_count);
        if (fail_count == 0 && open_count == 0) begin
            $display("PASS glass_tile_source_coordinates");
        end else begin
            $display("FAIL glass_tile_source_coordinates");
        end
        $finish;
    end

    // hard stop well beyond the slowest expected run
    initial begin
        #5_000_000;
        $display("FAIL glass_tile_source_coordinates");
        $finish;
    end

endmodule

>>> glass_tile_source_coordinates.f
rtl/gtsc_pkg.sv
rtl/glass_tile_source_coordinates.sv
rtl/gtsc_checker.sv
tb/glass_scan_checker.sv
tb/tb.sv
